/* hdl/swpq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpq_pkg: shared types and constants of the square-wave presence qualifier
// request codes, checker steps, edge kinds, register indexes and the
// command bundle from the controller to the datapath
// ----------------------------------------------------------------------------
package swpq_pkg;

	// parameter defaults
	localparam int CHANNELS_DEF   = 4;
	localparam int STAMP_BITS_DEF = 16;

	// field widths
	localparam int REQ_W      = 2;
	localparam int CH_W       = 2;
	localparam int TS_W       = 16;
	localparam int FLAG_W     = 4;
	localparam int TP_W       = 16;
	localparam int WID_W      = 32;
	localparam int CNT_W      = 16;
	localparam int OVF_W      = 13;
	localparam int MASK_W     = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int PROD_W     = TP_W + OVF_W;
	localparam int FACTOR_W   = 6;

	// channels a poll can visit (active mask and result flags are four wide)
	localparam int POLL_MAX = 4;

	localparam logic [OVF_W-1:0]    OVF_LIMIT      = 13'd5000;
	localparam logic [FACTOR_W-1:0] SILENCE_FACTOR = 6'd35;

	// request codes
	localparam logic [REQ_W-1:0] REQ_TICK    = 2'd0;
	localparam logic [REQ_W-1:0] REQ_CAPTURE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_POLL    = 2'd2;

	// edge kinds
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_FALL = 2'd1;
	localparam logic [1:0] KIND_RISE = 2'd2;
	localparam logic [1:0] KIND_MASK = 2'h3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TIMER_PERIOD   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_MIN      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_MAX      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIODS_NEEDED = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_MASK    = 3'd4;

	// register reset values
	localparam logic [TP_W-1:0]   TP_RESET   = 16'hFFFF;
	localparam logic [WID_W-1:0]  WMIN_RESET = 32'd0;
	localparam logic [WID_W-1:0]  WMAX_RESET = 32'd65535;
	localparam logic [CNT_W-1:0]  PN_RESET   = 16'd16;
	localparam logic [MASK_W-1:0] MASK_RESET = 4'd0;

	typedef enum logic [1:0] {
		STEP_RESTART = 2'd0,
		STEP_CLEAR   = 2'd1,
		STEP_HIGH    = 2'd2,
		STEP_LOW     = 2'd3
	} step_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_MUL    = 2'd1,
		ST_UPD    = 2'd2,
		ST_RESULT = 2'd3
	} state_t;

	typedef struct packed {
		logic            tick;
		logic            capture;
		logic            poll_start;
		logic            mul;
		logic            upd;
		logic            result_load;
		logic [CH_W-1:0] ch;
	} swpq_cmd_t;

endpackage

/* hdl/swpq_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpq_in_if: request channel
// valid/ready handshake carrying one event request
// ----------------------------------------------------------------------------
interface swpq_in_if;
	import swpq_pkg::*;

	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [CH_W-1:0]   channel;
	logic [TS_W-1:0]   timestamp;

	modport source (output valid, output req_type, output channel, output timestamp,
		input ready);
	modport sink (input valid, input req_type, input channel, input timestamp,
		output ready);
endinterface

/* hdl/swpq_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpq_out_if: result channel
// valid/ready handshake carrying the per-channel flags
// ----------------------------------------------------------------------------
interface swpq_out_if;
	import swpq_pkg::*;

	logic              valid;
	logic              ready;
	logic [FLAG_W-1:0] pass_mask;
	logic [FLAG_W-1:0] edge_rising_next;

	modport source (output valid, output pass_mask, output edge_rising_next, input ready);
	modport sink (input valid, input pass_mask, input edge_rising_next, output ready);
endinterface

/* hdl/swpq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpq_ctrl: request sequencer
// accepts requests, walks the poll over the channels and owns result valid
// ----------------------------------------------------------------------------
module swpq_ctrl #(
	parameter int CHANNELS = swpq_pkg::CHANNELS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [swpq_pkg::REQ_W-1:0]   in_req_type,
	output logic                         in_ready,
	output logic                         out_valid,
	input  logic                         out_ready,
	output swpq_pkg::swpq_cmd_t          cmd
);
	import swpq_pkg::*;

	localparam int NPOLL = (CHANNELS < POLL_MAX) ? CHANNELS : POLL_MAX;
	localparam logic [CH_W-1:0] LAST_CH = CH_W'(NPOLL - 1);

	state_t          state_q, state_d;
	logic [CH_W-1:0] ch_q, ch_d;
	logic            out_valid_q, out_valid_d;
	logic            accept;
	logic            slot_free;

	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			ch_q        <= ch_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		ch_d        = ch_q;
		in_ready    = 1'b0;
		out_valid_d = out_valid_q && !out_ready;
		cmd         = '0;
		cmd.ch      = ch_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (accept) begin
					unique case (in_req_type)
						REQ_TICK: begin
							cmd.tick = 1'b1;
							state_d  = ST_RESULT;
						end
						REQ_CAPTURE: begin
							cmd.capture = 1'b1;
							state_d     = ST_RESULT;
						end
						REQ_POLL: begin
							cmd.poll_start = 1'b1;
							ch_d           = '0;
							state_d        = ST_MUL;
						end
						default: state_d = ST_RESULT;
					endcase
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_UPD;
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				if (ch_q == LAST_CH) begin
					state_d = ST_RESULT;
				end else begin
					ch_d    = ch_q + 1'b1;
					state_d = ST_MUL;
				end
			end
			ST_RESULT: begin
				if (slot_free) begin
					cmd.result_load = 1'b1;
					out_valid_d     = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_load_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.result_load |-> (!out_valid_q || out_ready))
		else $error("result overwrote an unread result");

	a_poll_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL || state_q == ST_UPD) |-> (ch_q <= LAST_CH))
		else $error("poll channel out of range");

	a_last_upd_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD && ch_q == LAST_CH) |=> (state_q == ST_RESULT))
		else $error("poll did not finish after last channel");

	a_mul_then_upd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |=> (state_q == ST_UPD && $stable(ch_q)))
		else $error("product stage not followed by update of same channel");
endmodule

/* hdl/swpq_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpq_datapath: channel state, width arithmetic and result register
// holds per-channel checker state, config registers and the output flags
// ----------------------------------------------------------------------------
module swpq_datapath #(
	parameter int CHANNELS   = swpq_pkg::CHANNELS_DEF,
	parameter int STAMP_BITS = swpq_pkg::STAMP_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  swpq_pkg::swpq_cmd_t               cmd,
	input  logic [swpq_pkg::CH_W-1:0]         channel,
	input  logic [swpq_pkg::TS_W-1:0]         timestamp,
	input  logic                              cfg_wr_en,
	input  logic [swpq_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [swpq_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic [swpq_pkg::FLAG_W-1:0]       pass_mask,
	output logic [swpq_pkg::FLAG_W-1:0]       edge_rising_next
);
	import swpq_pkg::*;

	localparam int NPOLL = (CHANNELS < POLL_MAX) ? CHANNELS : POLL_MAX;

	// config registers
	logic [TP_W-1:0]   tp_q;
	logic [WID_W-1:0]  wmin_q;
	logic [WID_W-1:0]  wmax_q;
	logic [CNT_W-1:0]  pn_q;
	logic [MASK_W-1:0] mask_q;

	// per-channel state
	logic [STAMP_BITS-1:0] rise_q [CHANNELS];
	logic [STAMP_BITS-1:0] fall_q [CHANNELS];
	logic [OVF_W-1:0]      ovf_cnt_q [CHANNELS];
	logic [OVF_W-1:0]      ovf_sav_q [CHANNELS];
	logic [1:0]            kind_q [CHANNELS];
	step_t                 step_q [CHANNELS];
	logic [CNT_W-1:0]      good_q [CHANNELS];
	logic [WID_W-1:0]      lw_q [CHANNELS];
	logic [CHANNELS-1:0]   expect_q;
	logic [CHANNELS-1:0]   pass_q;

	logic [STAMP_BITS-1:0] ts_q;
	logic [STAMP_BITS-1:0] ts_in;
	logic [WID_W-1:0]      ts_wide;

	// product stage
	logic [PROD_W-1:0] live_prod_s1;
	logic [PROD_W-1:0] sav_prod_s1;
	logic [WID_W-1:0]  lw35_s1;

	// selected channel
	logic [CHANNELS-1:0]   hit;
	logic [CHANNELS-1:0]   upd_hit;
	logic [STAMP_BITS-1:0] rise_sel, fall_sel, lo_sel;
	logic [OVF_W-1:0]      ovf_cnt_sel, ovf_sav_sel;
	logic [WID_W-1:0]      lw_sel;

	logic [WID_W-1:0] lo32, live, wh, wl;
	logic             silent, ok_h, ok_l;

	logic [FLAG_W-1:0] pass_mask_q, edge_q;
	logic [FLAG_W-1:0] pass_vec, edge_vec;

	assign ts_wide = WID_W'(timestamp);
	assign ts_in   = ts_wide[STAMP_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tp_q   <= TP_RESET;
			wmin_q <= WMIN_RESET;
			wmax_q <= WMAX_RESET;
			pn_q   <= PN_RESET;
			mask_q <= MASK_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx)
				CFG_TIMER_PERIOD:   tp_q   <= cfg_data[TP_W-1:0];
				CFG_WIDTH_MIN:      wmin_q <= cfg_data[WID_W-1:0];
				CFG_WIDTH_MAX:      wmax_q <= cfg_data[WID_W-1:0];
				CFG_PERIODS_NEEDED: pn_q   <= cfg_data[CNT_W-1:0];
				CFG_ACTIVE_MASK:    mask_q <= cfg_data[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	// channel hit by the poll walk, gated by the active mask
	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			hit[c]     = (c < NPOLL) && (WID_W'(cmd.ch) == c);
			upd_hit[c] = 1'b0;
			if (c < NPOLL) begin
				upd_hit[c] = hit[c] && mask_q[c % MASK_W];
			end
		end
	end

	always_comb begin
		rise_sel    = '0;
		fall_sel    = '0;
		ovf_cnt_sel = '0;
		ovf_sav_sel = '0;
		lw_sel      = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			if (hit[c]) begin
				rise_sel    = rise_q[c];
				fall_sel    = fall_q[c];
				ovf_cnt_sel = ovf_cnt_q[c];
				ovf_sav_sel = ovf_sav_q[c];
				lw_sel      = lw_q[c];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.poll_start) begin
			ts_q <= ts_in;
		end
		if (cmd.mul) begin
			live_prod_s1 <= tp_q * ovf_cnt_sel;
			sav_prod_s1  <= tp_q * ovf_sav_sel;
			lw35_s1      <= lw_sel * SILENCE_FACTOR;
		end
	end

	// width arithmetic, wrapping at 32 bits
	assign lo_sel = (rise_sel < fall_sel) ? rise_sel : fall_sel;
	assign lo32   = WID_W'(lo_sel);
	assign live   = (ovf_cnt_sel != '0) ? (WID_W'(live_prod_s1) - lo32)
		: (WID_W'(ts_q) - lo32);
	assign silent = (lw_sel != '0) && (live > lw35_s1);
	assign wh     = WID_W'(sav_prod_s1) + WID_W'(rise_sel) - WID_W'(fall_sel);
	assign wl     = WID_W'(sav_prod_s1) + WID_W'(fall_sel) - WID_W'(rise_sel);
	assign ok_h   = (wh > wmin_q) && (wh < wmax_q);
	assign ok_l   = (wl > wmin_q) && (wl < wmax_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				rise_q[c]    <= '0;
				fall_q[c]    <= '0;
				ovf_cnt_q[c] <= '0;
				ovf_sav_q[c] <= '0;
				kind_q[c]    <= KIND_NONE;
				step_q[c]    <= STEP_RESTART;
				good_q[c]    <= '0;
				lw_q[c]      <= '0;
			end
			expect_q <= '1;
			pass_q   <= '0;
		end else begin
			for (int c = 0; c < CHANNELS; c++) begin
				if (cmd.tick) begin
					ovf_cnt_q[c] <= (ovf_cnt_q[c] < OVF_LIMIT) ? ovf_cnt_q[c] + 1'b1 : '0;
				end
				if (cmd.capture && (WID_W'(channel) == c)) begin
					ovf_sav_q[c] <= ovf_cnt_q[c];
					ovf_cnt_q[c] <= '0;
					if (expect_q[c]) begin
						rise_q[c]   <= ts_in;
						kind_q[c]   <= KIND_RISE;
						expect_q[c] <= 1'b0;
					end else begin
						fall_q[c]   <= ts_in;
						kind_q[c]   <= KIND_FALL;
						expect_q[c] <= 1'b1;
					end
				end
				if (cmd.upd && upd_hit[c]) begin
					case (step_q[c])
						STEP_RESTART: begin
							step_q[c]   <= STEP_CLEAR;
							kind_q[c]   <= KIND_NONE;
							lw_q[c]     <= '0;
							expect_q[c] <= 1'b1;
						end
						STEP_CLEAR: begin
							good_q[c] <= '0;
							pass_q[c] <= 1'b0;
							step_q[c] <= STEP_HIGH;
						end
						STEP_HIGH: begin
							if ((kind_q[c] & KIND_MASK) == KIND_RISE) begin
								lw_q[c]   <= wh;
								kind_q[c] <= KIND_NONE;
								step_q[c] <= ok_h ? STEP_LOW : STEP_CLEAR;
							end else if (silent) begin
								step_q[c] <= STEP_RESTART;
							end
						end
						default: begin
							if ((kind_q[c] & KIND_MASK) == KIND_FALL) begin
								lw_q[c]   <= wl;
								kind_q[c] <= KIND_NONE;
								if (ok_l) begin
									step_q[c] <= STEP_HIGH;
									if (good_q[c] < pn_q) begin
										good_q[c] <= good_q[c] + 1'b1;
									end else begin
										pass_q[c] <= 1'b1;
									end
								end else begin
									step_q[c] <= STEP_CLEAR;
								end
							end else if (silent) begin
								step_q[c] <= STEP_RESTART;
							end
						end
					endcase
				end
			end
		end
	end

	// flags of the channels the result reports
	for (genvar b = 0; b < FLAG_W; b++) begin : g_flags
		if (b < CHANNELS) begin : g_used
			assign pass_vec[b] = pass_q[b];
			assign edge_vec[b] = expect_q[b];
		end else begin : g_unused
			assign pass_vec[b] = 1'b0;
			assign edge_vec[b] = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.result_load) begin
			pass_mask_q <= pass_vec;
			edge_q      <= edge_vec;
		end
	end

	assign pass_mask        = pass_mask_q;
	assign edge_rising_next = edge_q;

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.tick, cmd.capture, cmd.poll_start, cmd.mul, cmd.upd, cmd.result_load}))
		else $error("datapath commands overlap");

	for (genvar c = 0; c < CHANNELS; c++) begin : g_chk
		a_ovf_bound: assert property (@(posedge clk) disable iff (!arst_n)
			ovf_cnt_q[c] <= OVF_LIMIT)
			else $error("overflow count past wrap limit");

		a_pass_hold: assert property (@(posedge clk) disable iff (!arst_n)
			($rose(pass_q[c])) |-> $past(cmd.upd))
			else $error("pass flag set outside a checker update");
	end
endmodule

/* hdl/square_wave_presence_qualifier.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// square_wave_presence_qualifier: four-channel square-wave qualifier
// tick, edge capture and poll requests drive per-channel width checkers
// ----------------------------------------------------------------------------
// tick, capture and unused requests go to the result state, which waits for a free output slot
// a poll runs multiply then update for each of min(CHANNELS, 4) channels, then the result state
// one request at a time: a request is accepted only while the sequencer is idle
// the poll walks the channels through one shared multiply stage and one update stage
// a new request is taken while the previous result still waits in the output register
// reset: async, active low; all channel state and config registers reset at once
module square_wave_presence_qualifier #(
	parameter int CHANNELS   = swpq_pkg::CHANNELS_DEF,
	parameter int STAMP_BITS = swpq_pkg::STAMP_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	swpq_in_if.sink                          in_ch,
	swpq_out_if.source                       out_ch,
	input  logic                             cfg_wr_en,
	input  logic [swpq_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [swpq_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import swpq_pkg::*;

	// command bundle from the sequencer to the datapath
	swpq_cmd_t cmd;

	// sequencer: request decode, poll walk over the channels, result valid
	swpq_ctrl #(
		.CHANNELS (CHANNELS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_ch.valid),
		.in_req_type (in_ch.req_type),
		.in_ready    (in_ch.ready),
		.out_valid   (out_ch.valid),
		.out_ready   (out_ch.ready),
		.cmd         (cmd)
	);

	// datapath: tick and capture land at the accept edge, poll runs per channel
	swpq_datapath #(
		.CHANNELS   (CHANNELS),
		.STAMP_BITS (STAMP_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.channel          (in_ch.channel),
		.timestamp        (in_ch.timestamp),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_idx          (cfg_idx),
		.cfg_data         (cfg_data),
		.pass_mask        (out_ch.pass_mask),
		.edge_rising_next (out_ch.edge_rising_next)
	);
endmodule
